// ----- sv/tewu_pkg.sv -----
package tewu_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W = 18;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] frame;
    logic [15:0] tag;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rot;
  } cell_ctrl_t;

  typedef struct packed {
    logic   has_event;
    entry_t ev;
    logic   accepted;
    logic   final_res;
  } result_t;

endpackage

// ----- sv/tewu_cell.sv -----
module tewu_cell (
  input  logic                clk,
  input  tewu_pkg::cell_ctrl_t ctrl,
  input  logic                live,
  input  logic                at_end,
  input  tewu_pkg::entry_t    new_entry,
  input  tewu_pkg::entry_t    left_entry,
  input  logic                left_gt,
  input  tewu_pkg::entry_t    right_entry,
  output tewu_pkg::entry_t    entry,
  output logic                gt
);
  import tewu_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign gt    = live && (entry_r.frame > new_entry.frame);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.rot) begin
      entry_nxt = right_entry;
    end else if (ctrl.ins) begin
      // later entries move one cell up, the new one lands after equal frames
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || at_end) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- sv/timeline_event_window_unit.sv -----
// channel  | ports                                        | transfer when
// ---------+----------------------------------------------+---------------------
// input    | in_kind, in_event_*, in_*_position,          | in_valid & in_ready
//          | in_clip_start, in_clip_end, in_wraps         |
// result   | out_has_event, out_frame, out_tag,           | out_valid & out_ready
//          | out_payload, out_accepted, out_final_res     |
//
// add, clear and unused kinds finish in idle; an add inserts into the cell row in parallel.
// a query passes a setup state, then TABLE_DEPTH rotation steps of the cell row
// (2 * TABLE_DEPTH on a looped backward move), then a finish state for the last result.
// the row rotates one cell per step; a step waits while a match would push a held hit
// into a full result register. rst_n (synchronous) empties the table and clears out_valid.
module timeline_event_window_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [16:0] in_event_frame,
  input  logic [15:0]        in_event_tag,
  input  logic [31:0]        in_event_payload,
  input  logic signed [16:0] in_prev_position,
  input  logic signed [16:0] in_cur_position,
  input  logic signed [16:0] in_clip_start,
  input  logic signed [16:0] in_clip_end,
  input  logic               in_wraps,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_has_event,
  output logic [15:0]        out_frame,
  output logic [15:0]        out_tag,
  output logic [31:0]        out_payload,
  output logic               out_accepted,
  output logic               out_final_res
);
  import tewu_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             pass_r, pass_nxt;
  logic             two_pass_r, two_pass_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             held_valid_r, held_valid_nxt;
  result_t          out_res_r, out_res_nxt;
  entry_t           held_r, held_nxt;

  logic signed [16:0] q_prev_r, q_cur_r, q_first_r, q_last_r;
  logic               q_wraps_r;
  logic signed [POS_W-1:0] lo_a_r, hi_a_r, lo_b_r, hi_b_r;
  logic signed [POS_W-1:0] lo_a_nxt, hi_a_nxt, lo_b_nxt, hi_b_nxt;

  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     cell_entry [TABLE_DEPTH];
  logic       cell_gt    [TABLE_DEPTH];

  logic accept, out_free, add_ok;
  logic match, scan_go, idx_last, head_live;
  logic signed [POS_W-1:0] head_f, lo_sel, hi_sel;
  logic signed [POS_W-1:0] s_first, s_last, s_lo, s_hi, s_prev, s_cur, c_prev, c_cur;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign add_ok   = !in_event_frame[16] && (in_event_tag != 16'd0) &&
                    (count_r < CNT_W'(TABLE_DEPTH));

  assign new_entry.frame   = in_event_frame[15:0];
  assign new_entry.tag     = in_event_tag;
  assign new_entry.payload = in_event_payload;

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_g = 1'b0;
    end else begin : g_rest
      assign left_e = cell_entry[i-1];
      assign left_g = cell_gt[i-1];
    end
    tewu_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .live        (CNT_W'(i) < count_r),
      .at_end      (count_r == CNT_W'(i)),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (cell_entry[(i + 1) % TABLE_DEPTH]),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  // window setup from the captured query
  always_comb begin
    s_first = {q_first_r[16], q_first_r};
    s_last  = {q_last_r[16], q_last_r};
    s_prev  = {q_prev_r[16], q_prev_r};
    s_cur   = {q_cur_r[16], q_cur_r};
    s_lo    = (s_first > s_last) ? s_last : s_first;
    s_hi    = (s_first > s_last) ? s_first : s_last;
    c_prev  = (s_prev < s_lo) ? s_lo : ((s_prev > s_hi) ? s_hi : s_prev);
    c_cur   = (s_cur < s_lo) ? s_lo : ((s_cur > s_hi) ? s_hi : s_cur);
  end

  // head cell test
  assign head_f    = {2'b00, cell_entry[0].frame};
  assign head_live = CNT_W'(idx_r) < count_r;
  assign lo_sel    = pass_r ? lo_b_r : lo_a_r;
  assign hi_sel    = pass_r ? hi_b_r : hi_a_r;
  assign match     = head_live && (head_f >= lo_sel) && (head_f <= hi_sel);
  assign scan_go   = !(match && held_valid_r && !out_free);
  assign idx_last  = (idx_r == IDX_W'(TABLE_DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_QUERY)) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_go && idx_last && !(!pass_r && two_pass_r)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ctrl           = '0;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pass_nxt       = pass_r;
    two_pass_nxt   = two_pass_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    lo_a_nxt       = lo_a_r;
    hi_a_nxt       = hi_a_r;
    lo_b_nxt       = lo_b_r;
    hi_b_nxt       = hi_b_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_res_nxt           = '0;
          out_res_nxt.accepted  = 1'b1;
          out_res_nxt.final_res = 1'b1;
          case (in_kind)
            KIND_ADD: begin
              out_valid_nxt        = 1'b1;
              out_res_nxt.accepted = add_ok;
              if (add_ok) begin
                ctrl.ins  = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_CLEAR: begin
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
            end
            KIND_QUERY: begin
              idx_nxt        = '0;
              pass_nxt       = 1'b0;
              held_valid_nxt = 1'b0;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_SETUP: begin
        lo_a_nxt = c_prev + POS_W'(1);
        if (!q_wraps_r || (c_cur >= c_prev)) begin
          hi_a_nxt     = c_cur;
          two_pass_nxt = 1'b0;
        end else begin
          // looped backward: tail of the clip first, then the head
          hi_a_nxt     = s_hi;
          two_pass_nxt = 1'b1;
        end
        lo_b_nxt = s_lo;
        hi_b_nxt = c_cur;
      end
      ST_SCAN: begin
        if (scan_go) begin
          ctrl.rot = 1'b1;
          if (match) begin
            if (held_valid_r) begin
              out_valid_nxt         = 1'b1;
              out_res_nxt.has_event = 1'b1;
              out_res_nxt.ev        = held_r;
              out_res_nxt.accepted  = 1'b1;
              out_res_nxt.final_res = 1'b0;
            end
            held_nxt       = cell_entry[0];
            held_valid_nxt = 1'b1;
          end
          if (idx_last) begin
            idx_nxt  = '0;
            pass_nxt = !pass_r && two_pass_r;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_res_nxt           = '0;
          out_res_nxt.has_event = held_valid_r;
          if (held_valid_r) out_res_nxt.ev = held_r;
          out_res_nxt.accepted  = 1'b1;
          out_res_nxt.final_res = 1'b1;
          held_valid_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      pass_r       <= 1'b0;
      two_pass_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      pass_r       <= pass_nxt;
      two_pass_r   <= two_pass_nxt;
      out_valid_r  <= out_valid_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    held_r    <= held_nxt;
    lo_a_r    <= lo_a_nxt;
    hi_a_r    <= hi_a_nxt;
    lo_b_r    <= lo_b_nxt;
    hi_b_r    <= hi_b_nxt;
    if (accept) begin
      q_prev_r  <= in_prev_position;
      q_cur_r   <= in_cur_position;
      q_first_r <= in_clip_start;
      q_last_r  <= in_clip_end;
      q_wraps_r <= in_wraps;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_has_event = out_res_r.has_event;
  assign out_frame     = out_res_r.ev.frame;
  assign out_tag       = out_res_r.ev.tag;
  assign out_payload   = out_res_r.ev.payload;
  assign out_accepted  = out_res_r.accepted;
  assign out_final_res = out_res_r.final_res;

endmodule

// ----- bench/timeline_event_window_unit_tb.sv -----
module timeline_event_window_unit_tb;
  import tewu_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int PRINT_LIMIT = 30;

  localparam result_t RES_DONE =
    '{has_event: 1'b0, ev: '0, accepted: 1'b1, final_res: 1'b1};
  localparam result_t RES_REJECTED =
    '{has_event: 1'b0, ev: '0, accepted: 1'b0, final_res: 1'b1};

  typedef struct {
    logic [1:0]         kind;
    logic signed [16:0] frame;
    logic [15:0]        tag;
    logic [31:0]        payload;
    logic signed [16:0] prev_pos;
    logic signed [16:0] cur_pos;
    logic signed [16:0] clip_start;
    logic signed [16:0] clip_end;
    logic               wraps;
  } cue_t;

  typedef struct {
    cue_t    cue;
    bit      fixed;
    result_t want;
  } cue_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_kind;
  logic signed [16:0] in_event_frame;
  logic [15:0]        in_event_tag;
  logic [31:0]        in_event_payload;
  logic signed [16:0] in_prev_position;
  logic signed [16:0] in_cur_position;
  logic signed [16:0] in_clip_start;
  logic signed [16:0] in_clip_end;
  logic               in_wraps;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_has_event;
  logic [15:0]        out_frame;
  logic [15:0]        out_tag;
  logic [31:0]        out_payload;
  logic               out_accepted;
  logic               out_final_res;

  // predictor copy of the event table
  logic [15:0] table_frame [TABLE_DEPTH];
  logic [15:0] table_tag [TABLE_DEPTH];
  logic [31:0] table_payload [TABLE_DEPTH];
  int          table_count = 0;

  result_t  expected_results[$];
  cue_row_t plan[$];
  int       fail_count = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  bit       tx_steady = 1'b0;
  bit       rx_steady = 1'b0;

  always #1 clk = ~clk;

  timeline_event_window_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_event_frame   (in_event_frame),
    .in_event_tag     (in_event_tag),
    .in_event_payload (in_event_payload),
    .in_prev_position (in_prev_position),
    .in_cur_position  (in_cur_position),
    .in_clip_start    (in_clip_start),
    .in_clip_end      (in_clip_end),
    .in_wraps         (in_wraps),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_has_event    (out_has_event),
    .out_frame        (out_frame),
    .out_tag          (out_tag),
    .out_payload      (out_payload),
    .out_accepted     (out_accepted),
    .out_final_res    (out_final_res)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // fields that the kind does not use carry random noise
  function automatic cue_t bare_cue(input logic [1:0] kind);
    cue_t c;
    c.kind       = kind;
    c.frame      = 17'($urandom);
    c.tag        = 16'($urandom);
    c.payload    = $urandom;
    c.prev_pos   = 17'($urandom);
    c.cur_pos    = 17'($urandom);
    c.clip_start = 17'($urandom);
    c.clip_end   = 17'($urandom);
    c.wraps      = 1'($urandom);
    return c;
  endfunction

  function automatic cue_t add_cue(input int f, input int tag, input logic [31:0] payload);
    cue_t c;
    c         = bare_cue(KIND_ADD);
    c.frame   = 17'(f);
    c.tag     = 16'(tag);
    c.payload = payload;
    return c;
  endfunction

  function automatic cue_t query_cue(input int prv, input int cur, input int lo, input int hi,
                                     input logic wr);
    cue_t c;
    c            = bare_cue(KIND_QUERY);
    c.prev_pos   = 17'(prv);
    c.cur_pos    = 17'(cur);
    c.clip_start = 17'(lo);
    c.clip_end   = 17'(hi);
    c.wraps      = wr;
    return c;
  endfunction

  function automatic logic signed [16:0] near_pos();
    return 17'(int'($urandom_range(0, 96)) - 16);
  endfunction

  function automatic cue_t random_add();
    cue_t c;
    int   r;
    c      = bare_cue(KIND_ADD);
    r      = $urandom_range(0, 19);
    if (r == 0) c.frame = 17'(-int'($urandom_range(1, 65536)));
    else if (r < 4) c.frame = 17'($urandom_range(0, 65535));
    else c.frame = 17'($urandom_range(0, 63));
    if (r == 1) c.tag = '0;
    else if (c.tag == '0) c.tag = 16'd1;
    return c;
  endfunction

  function automatic cue_t random_query();
    cue_t               c;
    logic signed [16:0] swap;
    c = bare_cue(KIND_QUERY);
    // mostly positions near the stored frames, else anywhere
    if ($urandom_range(0, 4) != 0) begin
      c.prev_pos   = near_pos();
      c.cur_pos    = near_pos();
      c.clip_start = 17'(int'($urandom_range(0, 16)) - 8);
      c.clip_end   = 17'($urandom_range(40, 72));
      if ($urandom_range(0, 3) == 0) begin
        swap         = c.clip_start;
        c.clip_start = c.clip_end;
        c.clip_end   = swap;
      end
    end
    return c;
  endfunction

  function automatic void plan_fixed(input cue_t c, input result_t want);
    cue_row_t row;
    row.cue   = c;
    row.fixed = 1'b1;
    row.want  = want;
    plan      = {plan, row};
  endfunction

  function automatic void plan_checked(input cue_t c);
    cue_row_t row;
    row.cue   = c;
    row.fixed = 1'b0;
    row.want  = RES_DONE;
    plan      = {plan, row};
  endfunction

  function automatic void predict_window(input cue_t c, ref result_t res[$]);
    int      f, prv, cur, first, last, held, nspan, pos;
    int      span_lo[2];
    int      span_hi[2];
    int      hits[$];
    result_t hit;
    res.delete();
    nspan = 0;
    case (c.kind)
      KIND_ADD: begin
        f = c.frame;
        if (f < 0 || c.tag == '0 || table_count >= TABLE_DEPTH) begin
          res = {res, RES_REJECTED};
        end else begin
          // shift larger frames up; equal frames stay ahead of the new one
          pos = table_count;
          while (pos > 0 && int'(table_frame[pos-1]) > f) begin
            table_frame[pos]   = table_frame[pos-1];
            table_tag[pos]     = table_tag[pos-1];
            table_payload[pos] = table_payload[pos-1];
            pos--;
          end
          table_frame[pos]   = 16'(f);
          table_tag[pos]     = c.tag;
          table_payload[pos] = c.payload;
          table_count++;
          res = {res, RES_DONE};
        end
      end
      KIND_CLEAR: begin
        table_count = 0;
        res = {res, RES_DONE};
      end
      KIND_QUERY: begin
        if (table_count > 0) begin
          prv   = c.prev_pos;
          cur   = c.cur_pos;
          first = c.clip_start;
          last  = c.clip_end;
          if (first > last) begin
            held  = first;
            first = last;
            last  = held;
          end
          prv = (prv < first) ? first : (prv > last) ? last : prv;
          cur = (cur < first) ? first : (cur > last) ? last : cur;
          span_lo[0] = prv + 1;
          if (!c.wraps || cur >= prv) begin
            span_hi[0] = cur;
            nspan      = 1;
          end else begin
            // looped backward move: tail of the clip, then its head
            span_hi[0] = last;
            span_lo[1] = first;
            span_hi[1] = cur;
            nspan      = 2;
          end
          for (int s = 0; s < nspan; s++) begin
            for (int i = 0; i < table_count; i++) begin
              if (int'(table_frame[i]) < span_lo[s]) continue;
              if (int'(table_frame[i]) > span_hi[s]) break;
              hits = {hits, i};
            end
          end
        end
        if (hits.size() == 0) res = {res, RES_DONE};
        foreach (hits[k]) begin
          hit.has_event  = 1'b1;
          hit.ev.frame   = table_frame[hits[k]];
          hit.ev.tag     = table_tag[hits[k]];
          hit.ev.payload = table_payload[hits[k]];
          hit.accepted   = 1'b1;
          hit.final_res  = (k == hits.size() - 1);
          res = {res, hit};
        end
      end
      default: res = {res, RES_DONE};
    endcase
  endfunction

  task automatic send_cue(input cue_t c, input bit fixed, input result_t want);
    int      gap;
    result_t produced[$];
    gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= c.kind;
    in_event_frame   <= c.frame;
    in_event_tag     <= c.tag;
    in_event_payload <= c.payload;
    in_prev_position <= c.prev_pos;
    in_cur_position  <= c.cur_pos;
    in_clip_start    <= c.clip_start;
    in_clip_end      <= c.clip_end;
    in_wraps         <= c.wraps;
    do @(posedge clk); while (!in_ready);
    predict_window(c, produced);
    if (fixed) expected_results = {expected_results, want};
    else expected_results = {expected_results, produced};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    // only the first few are printed, all are counted
    if (fail_count < PRINT_LIMIT) $display("result %0d: %s", results_seen, what);
    fail_count++;
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("result arrived with nothing expected");
      return;
    end
    want = expected_results.pop_front();
    if (out_has_event !== want.has_event)
      report_mismatch($sformatf("has_event %b, expected %b", out_has_event, want.has_event));
    if (out_frame !== want.ev.frame)
      report_mismatch($sformatf("frame %0d, expected %0d", out_frame, want.ev.frame));
    if (out_tag !== want.ev.tag)
      report_mismatch($sformatf("tag %h, expected %h", out_tag, want.ev.tag));
    if (out_payload !== want.ev.payload)
      report_mismatch($sformatf("payload %h, expected %h", out_payload, want.ev.payload));
    if (out_accepted !== want.accepted)
      report_mismatch($sformatf("accepted %b, expected %b", out_accepted, want.accepted));
    if (out_final_res !== want.final_res)
      report_mismatch($sformatf("final_res %b, expected %b", out_final_res, want.final_res));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeline_event_window_unit_tb failed");
      $finish;
    end
  end

  initial begin
    int random_items;
    int n_adds;
    int n_queries;
    bit first_episode;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_CLEAR;
    in_event_frame   = '0;
    in_event_tag     = '0;
    in_event_payload = '0;
    in_prev_position = '0;
    in_cur_position  = '0;
    in_clip_start    = '0;
    in_clip_end      = '0;
    in_wraps         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    plan_fixed(query_cue(-65536, 65535, -65536, 65535, 1'b1), RES_DONE);
    plan_fixed(add_cue(-1, 1, 32'h0), RES_REJECTED);
    plan_fixed(add_cue(-65536, 65535, 32'hffff_ffff), RES_REJECTED);
    plan_fixed(add_cue(7, 0, 32'h0000_1234), RES_REJECTED);
    plan_fixed(add_cue(0, 1, 32'h0), RES_DONE);
    plan_fixed(add_cue(65535, 65535, 32'hffff_ffff), RES_DONE);
    plan_fixed(add_cue(100, 16'h00a5, 32'h5a5a_0001), RES_DONE);
    plan_fixed(add_cue(100, 16'h5a00, 32'h5a5a_0002), RES_DONE);
    plan_fixed(add_cue(50, 16'h0033, 32'hdead_beef), RES_DONE);
    plan_fixed(add_cue(100, 16'h0101, 32'h0), RES_DONE);
    plan_checked(query_cue(-65536, 65535, -65536, 65535, 1'b0));
    plan_checked(query_cue(-1, 100, 0, 65535, 1'b0));
    plan_checked(query_cue(10, 150, 200, 0, 1'b0));
    plan_checked(query_cue(90, 60, 0, 65535, 1'b1));
    plan_checked(query_cue(90, 60, 0, 65535, 1'b0));
    plan_checked(query_cue(1, 10, 0, 65535, 1'b0));
    plan_checked(query_cue(65535, 0, -65536, 65535, 1'b1));
    plan_checked(query_cue(50, 50, 0, 65535, 1'b1));
    plan_checked(query_cue(-300, 70000, 100, 100, 1'b1));
    plan_fixed(bare_cue(KIND_UNUSED), RES_DONE);
    plan_fixed(bare_cue(KIND_CLEAR), RES_DONE);
    plan_fixed(query_cue(-65536, 65535, -65536, 65535, 1'b0), RES_DONE);
    foreach (plan[i]) send_cue(plan[i].cue, plan[i].fixed, plan[i].want);
    drain_results();

    // episodes: clear, fill with adds, then a run of queries mixed with stray adds and unused kinds
    random_items  = 0;
    first_episode = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady <= tx_steady;
      send_cue(bare_cue(KIND_CLEAR), 1'b0, RES_DONE);
      random_items++;
      if (first_episode || $urandom_range(0, 7) == 0)
        n_adds = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 3);
      else
        n_adds = $urandom_range(0, 12);
      repeat (n_adds) begin
        send_cue(random_add(), 1'b0, RES_DONE);
        random_items++;
      end
      n_queries = $urandom_range(2, 6);
      repeat (n_queries) begin
        if ($urandom_range(0, 9) == 0) send_cue(bare_cue(KIND_UNUSED), 1'b0, RES_DONE);
        if ($urandom_range(0, 7) == 0) begin
          send_cue(random_add(), 1'b0, RES_DONE);
          random_items++;
        end
        send_cue(random_query(), 1'b0, RES_DONE);
        random_items++;
        if ($urandom_range(0, 11) == 0) drain_results();
      end
      first_episode = 1'b0;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("timeline_event_window_unit_tb passed");
    else $display("timeline_event_window_unit_tb failed");
    $finish;
  end

endmodule

// ----- timeline_event_window_unit.f -----
sv/tewu_pkg.sv
sv/tewu_cell.sv
sv/timeline_event_window_unit.sv
bench/timeline_event_window_unit_tb.sv
